>>> design/cotp_pkg.sv
// Shared types, codes and reset values for the constant on-time PWM setpoint block.
package cotp_pkg;

    // field widths
    localparam int unsigned DUTY_W     = 16;
    localparam int unsigned ONTIME_W   = 14;
    localparam int unsigned ONCNT_W    = 10;
    localparam int unsigned PERIOD_W   = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // divider sizes: dividend is on_time << 10, divisor is duty << (0, 2 or 4)
    localparam int unsigned FRAC_SH    = 10;
    localparam int unsigned DVD_W      = ONTIME_W + FRAC_SH;
    localparam int unsigned MAX_SH     = 4;
    localparam int unsigned DVS_W      = DUTY_W + MAX_SH;
    localparam int unsigned DIV_STEPS  = DVD_W;
    localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUTY   = 3'd4;

    // register reset values (Q-format versions of the original float constants)
    localparam logic [ONTIME_W-1:0] ON_TIME_RST    = 14'd13517;
    localparam logic [DUTY_W-1:0]   MIN_DUTY_RST   = 16'd3379;
    localparam logic [DUTY_W-1:0]   SPLIT_LOW_RST  = 16'd13517;
    localparam logic [DUTY_W-1:0]   SPLIT_HIGH_RST = 16'd54067;
    localparam logic [DUTY_W-1:0]   MAX_DUTY_RST   = 16'd60293;
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = 8'd255;

    // band / prescaler codes
    typedef enum logic [1:0] {
        BAND_DIV1  = 2'd0,
        BAND_DIV4  = 2'd1,
        BAND_DIV16 = 2'd2,
        BAND_OFF   = 2'd3
    } cotp_band_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FINISH
    } cotp_state_t;

    typedef struct packed {
        logic start;     // latch request, update band state, seed divider
        logic step;      // one restoring-division step
        logic load_out;  // write period and output registers
    } cotp_cmd_t;

    typedef struct packed {
        logic duty_ok;   // duty on the input port is inside (min, max]
    } cotp_stat_t;

    // log2 of the prescaler ratio for a band
    function automatic logic [2:0] band_shift(input cotp_band_t band);
        logic [2:0] sh;
        case (band)
            BAND_DIV1: sh = 3'd0;
            BAND_DIV4: sh = 3'd2;
            default:   sh = 3'd4;
        endcase
        return sh;
    endfunction

endpackage

>>> design/cotp_ctrl.sv
// Controller: request handshake, divider step count and output handshake.
module cotp_ctrl
    import cotp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  cotp_stat_t stat,
    output cotp_cmd_t  cmd
);

    cotp_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    step_next  = '0;
                    state_next = stat.duty_ok ? ST_DIV : ST_FINISH;
                end
            end
            ST_DIV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

>>> design/cotp_dp.sv
// Datapath: config registers, band state, serial divider and output registers.
module cotp_dp
    import cotp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [DUTY_W-1:0]     duty_request,
    input  cotp_cmd_t             cmd,
    output cotp_stat_t            stat,
    output logic [1:0]            prescaler_code,
    output logic [ONCNT_W-1:0]    on_time_count,
    output logic [PERIOD_W-1:0]   period_count,
    output logic                  setup_reloaded,
    output logic                  in_range
);

    // configuration
    logic [ONTIME_W-1:0] on_time_reg;
    logic [DUTY_W-1:0]   min_duty_reg, split_low_reg, split_high_reg, max_duty_reg;

    // band state
    cotp_band_t          band_mode_reg;
    cotp_band_t          prescaler_reg;
    logic [ONCNT_W-1:0]  held_on_time_reg;
    logic [PERIOD_W-1:0] held_period_reg;
    logic                reloaded_reg;
    logic                item_ok_reg;

    // divider
    logic [DVD_W-1:0]    dvd_reg;
    logic [DVS_W-1:0]    rem_reg;
    logic [DVS_W-1:0]    dvs_reg;

    // output registers
    logic [1:0]          out_psc_reg;
    logic [ONCNT_W-1:0]  out_on_reg;
    logic [PERIOD_W-1:0] out_period_reg;
    logic                out_reload_reg;
    logic                out_ok_reg;

    logic                duty_ok;
    cotp_band_t          band;
    logic [2:0]          sh;
    logic [DVS_W:0]      rem_shift;
    logic [DVS_W+1:0]    diff;
    logic                qbit;
    logic [PERIOD_W-1:0] period_next;
    logic [DVD_W-1:0]    quot_m1;

    assign duty_ok = (duty_request > min_duty_reg) && (duty_request <= max_duty_reg);
    assign stat.duty_ok = duty_ok;

    always_comb
    begin
        if (duty_request > split_high_reg)
            band = BAND_DIV1;
        else if (duty_request > split_low_reg)
            band = BAND_DIV4;
        else
            band = BAND_DIV16;
        sh = band_shift(band);
    end

    // restoring division step
    assign rem_shift = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, dvs_reg};
    assign qbit      = !diff[DVS_W+1];

    // period = quotient - 1, clamped to 0..255; out of range keeps the held period
    assign quot_m1 = dvd_reg - 1'b1;
    always_comb
    begin
        if (!item_ok_reg)
            period_next = held_period_reg;
        else if (dvd_reg == '0)
            period_next = '0;
        else if (quot_m1 > DVD_W'(255))
            period_next = '1;
        else
            period_next = quot_m1[PERIOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_reg    <= ON_TIME_RST;
            min_duty_reg   <= MIN_DUTY_RST;
            split_low_reg  <= SPLIT_LOW_RST;
            split_high_reg <= SPLIT_HIGH_RST;
            max_duty_reg   <= MAX_DUTY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ON_TIME:    on_time_reg    <= cfg_data[ONTIME_W-1:0];
                CFG_MIN_DUTY:   min_duty_reg   <= cfg_data;
                CFG_SPLIT_LOW:  split_low_reg  <= cfg_data;
                CFG_SPLIT_HIGH: split_high_reg <= cfg_data;
                CFG_MAX_DUTY:   max_duty_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_mode_reg    <= BAND_OFF;
            prescaler_reg    <= BAND_DIV16;
            held_on_time_reg <= '0;
            held_period_reg  <= PERIOD_RST;
            reloaded_reg     <= 1'b0;
            item_ok_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                item_ok_reg <= duty_ok;
                if (duty_ok)
                begin
                    reloaded_reg <= (band != band_mode_reg);
                    if (band != band_mode_reg)
                    begin
                        band_mode_reg    <= band;
                        prescaler_reg    <= band;
                        held_on_time_reg <= ONCNT_W'(on_time_reg >> (4'd4 + {1'b0, sh}));
                    end
                end
                else
                begin
                    reloaded_reg     <= (band_mode_reg != BAND_OFF);
                    held_on_time_reg <= '0;
                    if (band_mode_reg != BAND_OFF)
                    begin
                        band_mode_reg <= BAND_OFF;
                        prescaler_reg <= BAND_DIV1;
                    end
                end
            end
            if (cmd.load_out)
                held_period_reg <= period_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dvd_reg <= {on_time_reg, {FRAC_SH{1'b0}}};
            rem_reg <= '0;
            dvs_reg <= DVS_W'(duty_request) << sh;
        end
        else if (cmd.step)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], qbit};
            rem_reg <= qbit ? diff[DVS_W-1:0] : rem_shift[DVS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_psc_reg    <= prescaler_reg;
            out_on_reg     <= held_on_time_reg;
            out_period_reg <= period_next;
            out_reload_reg <= reloaded_reg;
            out_ok_reg     <= item_ok_reg;
        end
    end

    assign prescaler_code = out_psc_reg;
    assign on_time_count  = out_on_reg;
    assign period_count   = out_period_reg;
    assign setup_reloaded = out_reload_reg;
    assign in_range       = out_ok_reg;

    a_band_psc: assert property (@(posedge clk) disable iff (!rst_n)
        band_mode_reg != BAND_OFF |-> prescaler_reg == band_mode_reg)
        else $error("prescaler disagrees with active band");

    a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        band_mode_reg == BAND_OFF |-> held_on_time_reg == '0)
        else $error("on-time count nonzero while output off");

    a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> dvs_reg != '0)
        else $error("divider running with zero divisor");

    a_out_off: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (out_ok_reg || out_on_reg == '0))
        else $error("rejected request delivered with on time");

endmodule

>>> design/constant_on_time_pwm_setpoint_core.sv
// Top level of the constant on-time PWM setpoint block.
//
// Usage:
//   A duty request (unsigned Q0.16) enters on duty_request with in_valid/in_ready.
//   One result comes back per request on out_valid/out_ready: prescaler code,
//   10-bit on-time count, 8-bit period count, a reload flag and an in-range flag.
//   Band thresholds and the on time are set through cfg_we/cfg_index/cfg_data
//   while the block is idle, a rule for the user that the block does not
//   enforce; writes take effect at once, no read-back.
// Sequence:
//   In range: the accepting edge latches the request and picks the band, the
//   restoring divider then steps through every bit of the 24-bit dividend,
//   and the output register is loaded once it is free, raising out_valid as
//   in_ready returns. Out of range skips the divider. in_ready is high only
//   while the controller is idle, so no request is taken until the last is loaded.
// Reset:
//   rst_n clears the config registers to their defaults, puts the band state
//   in output off with prescaler divide 16, on time 0 and period 255, and
//   drops out_valid.
// Stall:
//   A waiting result does not block the next request; its result is held in
//   the datapath until out_ready frees the output register.
module constant_on_time_pwm_setpoint_core
    import cotp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [DUTY_W-1:0]     duty_request,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            prescaler_code,
    output logic [ONCNT_W-1:0]    on_time_count,
    output logic [PERIOD_W-1:0]   period_count,
    output logic                  setup_reloaded,
    output logic                  in_range
);

    cotp_cmd_t  cmd;
    cotp_stat_t stat;

    // sequencing: request accept, divider steps, output handshake
    cotp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // config, band state, divider and result registers
    cotp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .duty_request   (duty_request),
        .cmd            (cmd),
        .stat           (stat),
        .prescaler_code (prescaler_code),
        .on_time_count  (on_time_count),
        .period_count   (period_count),
        .setup_reloaded (setup_reloaded),
        .in_range       (in_range)
    );

endmodule

>>> sim/tb_constant_on_time_pwm_setpoint_core.sv
// Self-checking testbench for the constant on-time PWM setpoint core.
module tb_constant_on_time_pwm_setpoint_core
    import cotp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Consecutive cycles with no handshake and no register write before the
    // run is declared hung. Worst honest case is a long request gap, a full
    // divide and a long result stall back to back, plus the phase pauses.
    localparam int unsigned HANG_LIMIT   = 1000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned PHASE_ITEMS  = 90;
    localparam int unsigned NUM_PHASES   = 6;

    // Register indexes the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_5 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    // One result as seen on the output ports.
    typedef struct packed {
        logic [1:0]          prescaler;
        logic [ONCNT_W-1:0]  on_cnt;
        logic [PERIOD_W-1:0] period;
        logic                reloaded;
        logic                accepted;
    } timer_setup_t;

    // ------------------------------------------------------------------
    // DUT signals, all inputs at known values from time zero
    // ------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [DUTY_W-1:0]     duty_request = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            prescaler_code;
    logic [ONCNT_W-1:0]    on_time_count;
    logic [PERIOD_W-1:0]   period_count;
    logic                  setup_reloaded;
    logic                  in_range;

    constant_on_time_pwm_setpoint_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .duty_request   (duty_request),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .prescaler_code (prescaler_code),
        .on_time_count  (on_time_count),
        .period_count   (period_count),
        .setup_reloaded (setup_reloaded),
        .in_range       (in_range)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block: config registers and band state
    // ------------------------------------------------------------------
    logic [ONTIME_W-1:0] sh_on_time    = ON_TIME_RST;
    logic [DUTY_W-1:0]   sh_min_duty   = MIN_DUTY_RST;
    logic [DUTY_W-1:0]   sh_split_low  = SPLIT_LOW_RST;
    logic [DUTY_W-1:0]   sh_split_high = SPLIT_HIGH_RST;
    logic [DUTY_W-1:0]   sh_max_duty   = MAX_DUTY_RST;

    cotp_band_t          sh_band      = BAND_OFF;
    logic [1:0]          sh_prescaler = BAND_DIV16;
    logic [ONCNT_W-1:0]  sh_on_cnt    = '0;
    logic [PERIOD_W-1:0] sh_period    = PERIOD_RST;

    // Bookkeeping shared by the stimulus, driver and monitor.
    logic [DUTY_W-1:0] pending_duties[$];
    timer_setup_t      expected_setups[$];
    int unsigned       reqs_queued   = 0;
    int unsigned       reqs_accepted = 0;
    int unsigned       setups_seen   = 0;
    int unsigned       error_count   = 0;
    int unsigned       idle_cycles   = 0;
    bit                no_idle       = 1'b0;   // stretch with both sides always ready
    logic              req_taken     = 1'b0;   // request handshake at the last rising edge
    int unsigned       req_gap       = 0;
    int unsigned       res_stall     = 0;

    // Timer settings the block should report for one request; advances the
    // shadow band state exactly as the hardware does.
    function automatic timer_setup_t next_timer_setup(input logic [DUTY_W-1:0] duty);
        timer_setup_t r;
        cotp_band_t   band;
        int unsigned  sh;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
        logic [DVD_W-1:0] quot;
        r.reloaded = 1'b0;
        r.accepted = 1'b0;
        if (duty > sh_min_duty && duty <= sh_max_duty)
        begin
            // thresholds are checked top down, whatever their order
            if (duty > sh_split_high)
                band = BAND_DIV1;
            else if (duty > sh_split_low)
                band = BAND_DIV4;
            else
                band = BAND_DIV16;
            sh = (band == BAND_DIV1) ? 0 : ((band == BAND_DIV4) ? 2 : 4);
            if (band != sh_band)
            begin
                sh_prescaler = band;
                sh_on_cnt    = ONCNT_W'(sh_on_time >> (4 + sh));
                sh_band      = band;
                r.reloaded   = 1'b1;
            end
            dividend = {sh_on_time, {FRAC_SH{1'b0}}};
            divisor  = DVS_W'(duty) << sh;
            quot     = dividend / DVD_W'(divisor);
            // clamp quotient - 1 into the 8-bit period
            if (quot == '0)
                sh_period = '0;
            else if (quot > 256)
                sh_period = '1;
            else
                sh_period = PERIOD_W'(quot - 1);
            r.accepted = 1'b1;
        end
        else
        begin
            // entering off forces divide 1; staying off rewrites nothing
            if (sh_band != BAND_OFF)
            begin
                sh_prescaler = BAND_DIV1;
                sh_band      = BAND_OFF;
                r.reloaded   = 1'b1;
            end
            sh_on_cnt = '0;
        end
        r.prescaler = sh_prescaler;
        r.on_cnt    = sh_on_cnt;
        r.period    = sh_period;
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Request gap: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    function automatic int unsigned pick_stall();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Request driver: changes at the falling edge, holds until taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !req_taken)
            ;   // still waiting for in_ready, payload held
        else if (req_gap != 0)
        begin
            in_valid <= 1'b0;
            req_gap  <= req_gap - 1;
        end
        else if (pending_duties.size() != 0)
        begin
            duty_request <= pending_duties.pop_front();
            in_valid     <= 1'b1;
            req_gap      <= pick_gap();
        end
        else
            in_valid <= 1'b0;
    end

    // Result-side back pressure.
    always @(negedge clk)
    begin
        if (res_stall != 0)
        begin
            out_ready <= 1'b0;
            res_stall <= res_stall - 1;
        end
        else if (!no_idle && $urandom_range(0, 7) == 0)
        begin
            out_ready <= 1'b0;
            res_stall <= pick_stall();
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: predict on request, check on result, watch for hangs
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        timer_setup_t got;
        timer_setup_t want;
        req_taken <= rst_n && in_valid && in_ready;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_setups.push_back(next_timer_setup(duty_request));
                reqs_accepted++;
            end
            if (out_valid && out_ready)
            begin
                got = '{prescaler_code, on_time_count, period_count,
                        setup_reloaded, in_range};
                if (expected_setups.size() == 0)
                    report_error($sformatf("result %0d arrived with nothing expected",
                                           setups_seen));
                else
                begin
                    want = expected_setups.pop_front();
                    if (got.prescaler != want.prescaler)
                        report_error($sformatf("result %0d prescaler_code %0d, want %0d",
                                               setups_seen, got.prescaler, want.prescaler));
                    if (got.on_cnt != want.on_cnt)
                        report_error($sformatf("result %0d on_time_count %0d, want %0d",
                                               setups_seen, got.on_cnt, want.on_cnt));
                    if (got.period != want.period)
                        report_error($sformatf("result %0d period_count %0d, want %0d",
                                               setups_seen, got.period, want.period));
                    if (got.reloaded != want.reloaded)
                        report_error($sformatf("result %0d setup_reloaded %0d, want %0d",
                                               setups_seen, got.reloaded, want.reloaded));
                    if (got.accepted != want.accepted)
                        report_error($sformatf("result %0d in_range %0d, want %0d",
                                               setups_seen, got.accepted, want.accepted));
                end
                setups_seen++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= HANG_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", HANG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_duty(input logic [DUTY_W-1:0] duty);
        pending_duties.push_back(duty);
        reqs_queued++;
    endtask

    // Register write; shadow copy follows with the same width masking.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_ON_TIME:    sh_on_time    = data[ONTIME_W-1:0];
            CFG_MIN_DUTY:   sh_min_duty   = data;
            CFG_SPLIT_LOW:  sh_split_low  = data;
            CFG_SPLIT_HIGH: sh_split_high = data;
            CFG_MAX_DUTY:   sh_max_duty   = data;
            default:        ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_thresholds(input int unsigned lo, input int unsigned sl,
                                    input int unsigned shi, input int unsigned hi);
        write_reg(CFG_MIN_DUTY,   CFG_DATA_W'(lo));
        write_reg(CFG_SPLIT_LOW,  CFG_DATA_W'(sl));
        write_reg(CFG_SPLIT_HIGH, CFG_DATA_W'(shi));
        write_reg(CFG_MAX_DUTY,   CFG_DATA_W'(hi));
    endtask

    // Block idle: every queued request taken and every result back.
    task automatic wait_idle();
        while (reqs_accepted != reqs_queued || expected_setups.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Duty values weighted toward the band edges, where the off-by-one
    // mistakes live, with a share of full-range and extreme values.
    function automatic logic [DUTY_W-1:0] pick_duty();
        int r;
        int base;
        r = $urandom_range(0, 9);
        if (r < 4)
        begin
            case ($urandom_range(0, 3))
                0:       base = sh_min_duty;
                1:       base = sh_split_low;
                2:       base = sh_split_high;
                default: base = sh_max_duty;
            endcase
            base = base + int'($urandom_range(0, 4)) - 2;
            if (base < 0)
                base = 0;
            if (base > 65535)
                base = 65535;
            return DUTY_W'(base);
        end
        if (r == 4)
        begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return DUTY_W'(1);
                default: return '1;
            endcase
        end
        if (r == 5)
            return DUTY_W'($urandom_range(1, 600));   // long periods, saturation
        if (r < 8 && sh_max_duty > sh_min_duty)
            return DUTY_W'($urandom_range(sh_min_duty + 1, sh_max_duty));
        return DUTY_W'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned th[$];
        logic [DUTY_W-1:0] directed[$];

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values: every band edge from both sides, same band twice,
        // off entered and held, off left again.
        directed = '{16'd0, 16'd3379, 16'd3380, 16'd3381, 16'd13517, 16'd13518,
                     16'd54067, 16'd54068, 16'd60293, 16'd60294, 16'd65535,
                     16'd65535, 16'd40000, 16'd1};
        foreach (directed[i])
            queue_duty(directed[i]);
        wait_idle();

        // Widest on time (write data wider than the register gets masked),
        // open range: period overflow on small duty, zero duty still off.
        write_reg(CFG_ON_TIME, 16'hFFFF);
        write_thresholds(0, 100, 200, 65535);
        directed = '{16'd1, 16'd65535, 16'd150, 16'd0, 16'd100, 16'd101};
        foreach (directed[i])
            queue_duty(directed[i]);
        wait_idle();

        // Zero on time: quotient 0 gives period 0. Writes to unused
        // indexes must change nothing.
        write_reg(CFG_ON_TIME, 16'h0000);
        write_reg(CFG_SPARE_5, 16'hFFFF);
        write_reg(CFG_SPARE_7, 16'h0000);
        directed = '{16'd30000, 16'd150, 16'd65535};
        foreach (directed[i])
            queue_duty(directed[i]);
        wait_idle();

        for (int unsigned ph = 0; ph < NUM_PHASES; ph++)
        begin
            no_idle = (ph == 1 || ph == 4);
            case (ph)
                0:
                begin
                    th.delete();
                    repeat (4) th.push_back($urandom_range(0, 65535));
                    th.sort();
                    write_reg(CFG_ON_TIME, CFG_DATA_W'($urandom));
                    write_thresholds(th[0], th[1], th[2], th[3]);
                end
                1:
                begin
                    // everything above zero lands in the divide-1 band
                    write_reg(CFG_ON_TIME, 16'h3FFF);
                    write_thresholds(0, 0, 0, 65535);
                end
                2:
                begin
                    // thresholds in any order
                    write_reg(CFG_ON_TIME, CFG_DATA_W'($urandom));
                    write_thresholds($urandom_range(0, 65535), $urandom_range(0, 65535),
                                     $urandom_range(0, 65535), $urandom_range(0, 65535));
                end
                3:
                begin
                    // empty window: output stays off
                    write_reg(CFG_ON_TIME, CFG_DATA_W'($urandom));
                    write_thresholds(65535, 65535, 65535, 0);
                end
                4:
                begin
                    th.delete();
                    repeat (4) th.push_back($urandom_range(0, 65535));
                    th.sort();
                    write_reg(CFG_ON_TIME, CFG_DATA_W'($urandom_range(0, 200)));
                    write_thresholds(th[0], th[1], th[2], th[3]);
                end
                default:
                begin
                    write_reg(CFG_ON_TIME, CFG_DATA_W'(ON_TIME_RST));
                    write_thresholds(MIN_DUTY_RST, SPLIT_LOW_RST, SPLIT_HIGH_RST,
                                     MAX_DUTY_RST);
                end
            endcase
            repeat (PHASE_ITEMS)
                queue_duty(pick_duty());
            wait_idle();
        end
        no_idle = 1'b0;

        // Drained; give a stray extra result time to show up.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_setups.size() != 0)
            report_error($sformatf("%0d results never arrived", expected_setups.size()));

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> constant_on_time_pwm_setpoint_core.f
design/cotp_pkg.sv
design/cotp_ctrl.sv
design/cotp_dp.sv
design/constant_on_time_pwm_setpoint_core.sv
sim/tb_constant_on_time_pwm_setpoint_core.sv
